[rtl/core/imh_pkg.sv]
// Package for the indexed min-heap: sizes, mode and status codes.
// No dependencies.
package imh_pkg;
    localparam int NUM_VERTICES = 1024;
    localparam int HEAP_SLOTS   = 1024;
    localparam int KEY_BITS     = 32;

    localparam int VERTEX_W = 10;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 11;
    localparam int CNT_W    = 10;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_LOOKUP = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DUP     = 2'd3
    } t_status;
endpackage

[rtl/core/imh_if.sv]
// Valid/ready channel interfaces for the indexed min-heap.
// Depends on imh_pkg.
interface imh_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [imh_pkg::VERTEX_W-1:0]  vertex;
    logic [imh_pkg::KEY_W-1:0]     key;
    modport source (output valid, mode, vertex, key, input ready);
    modport sink   (input valid, mode, vertex, key, output ready);
endinterface

interface imh_out_if;
    logic                          valid;
    logic                          ready;
    logic [imh_pkg::VERTEX_W-1:0]  popped_vertex;
    logic signed [imh_pkg::POS_W-1:0] heap_position;
    logic [1:0]                    status;
    logic [imh_pkg::CNT_W-1:0]     entry_count;
    modport source (output valid, popped_vertex, heap_position, status, entry_count,
                    input ready);
    modport sink   (input valid, popped_vertex, heap_position, status, entry_count,
                    output ready);
endinterface

[rtl/core/indexed_min_heap.sv]
// Top level of the indexed min-heap: sequencer, slot/position/key memories.
// Depends on imh_pkg and imh_if.
//
// channel | dir | payload                                          | transaction
// s_in    | in  | mode, vertex, key                                | valid & ready
// m_out   | out | popped_vertex, heap_position, status, entry_count| valid & ready
//
// One transaction at a time; the input stays low until the result is taken.
// A lookup, an empty pop or an ignored push or update goes straight to the result;
// push and update sift the vertex up level by level; pop moves the last entry to
// the root and sifts it down level by level. After reset a clearing pass marks
// every vertex absent; no transaction is taken until it ends.
module indexed_min_heap #(
    parameter int NUM_VERTICES = imh_pkg::NUM_VERTICES,
    parameter int HEAP_SLOTS   = imh_pkg::HEAP_SLOTS,
    parameter int KEY_BITS     = imh_pkg::KEY_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    imh_in_if.sink    s_in,
    imh_out_if.source m_out
);
    localparam int VW = imh_pkg::VERTEX_W;
    localparam int PW = imh_pkg::POS_W;
    localparam int CW = imh_pkg::CNT_W;
    localparam int NVA = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int SA  = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
    localparam int IW  = SA + 2;

    typedef enum logic [17:0] {
        S_CLR   = 18'h00001,
        S_IDLE  = 18'h00002,
        S_DEC   = 18'h00004,
        S_DEC2  = 18'h00008,
        S_POP1  = 18'h00010,
        S_POP2  = 18'h00020,
        S_UPRD  = 18'h00040,
        S_UPK1  = 18'h00080,
        S_UPK2  = 18'h00100,
        S_UPCMP = 18'h00200,
        S_DNRD  = 18'h00400,
        S_DNK1  = 18'h00800,
        S_DNK2  = 18'h01000,
        S_DNK3  = 18'h02000,
        S_DNCMP = 18'h04000,
        S_SWP1  = 18'h08000,
        S_SWP2  = 18'h10000,
        S_DONE  = 18'h20000
    } t_state;

    logic [VW-1:0]       r_slot_mem [HEAP_SLOTS];
    logic [PW-1:0]       r_pos_mem  [NUM_VERTICES];
    logic [KEY_BITS-1:0] r_key_mem  [NUM_VERTICES];

    t_state r_state, n_state;
    logic [NVA:0]        r_clr;
    logic [1:0]          r_mode;
    logic [VW-1:0]       r_v;
    logic [KEY_BITS-1:0] r_key;
    logic [CW:0]         r_cnt;
    logic [IW-1:0]       r_i, r_c;
    logic [VW-1:0]       r_va, r_vb, r_vc;
    logic [KEY_BITS-1:0] r_kb, r_kc;
    logic [1:0]          r_phase;
    logic [VW-1:0]       r_popped;
    logic [PW-1:0]       r_pos;
    logic [1:0]          r_status;
    logic                r_ovalid;

    logic [VW-1:0]       r_slot_rd;
    logic [PW-1:0]       r_pos_rd;
    logic [KEY_BITS-1:0] r_key_rd;

    logic          slot_we, pos_we, key_we;
    logic [SA-1:0] slot_wa, slot_ra;
    logic [VW-1:0] slot_wd;
    logic [NVA-1:0] pos_wa, pos_ra, key_wa, key_ra;
    logic [PW-1:0] pos_wd;
    logic          v_ok;
    logic [IW-1:0] parent, child;

    always_ff @(posedge i_clk) begin
        if (slot_we) r_slot_mem[slot_wa] <= slot_wd;
        r_slot_rd <= r_slot_mem[slot_ra];
        if (pos_we) r_pos_mem[pos_wa] <= pos_wd;
        r_pos_rd <= r_pos_mem[pos_ra];
        if (key_we) r_key_mem[key_wa] <= r_key;
        r_key_rd <= r_key_mem[key_ra];
    end

    assign v_ok   = 32'(r_v) < 32'(NUM_VERTICES);
    assign parent = (r_i - IW'(1)) >> 1;
    assign child  = {r_i[IW-2:0], 1'b1};
    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.popped_vertex = r_popped;
    assign m_out.heap_position = r_pos;
    assign m_out.status = r_status;
    assign m_out.entry_count = r_cnt[CW-1:0];

    // memory ports and next state
    always_comb begin
        n_state = r_state;
        slot_we = 1'b0; pos_we = 1'b0; key_we = 1'b0;
        slot_wa = r_i[SA-1:0]; slot_ra = r_i[SA-1:0]; slot_wd = r_va;
        pos_wa = r_va[NVA-1:0]; pos_ra = r_v[NVA-1:0]; pos_wd = PW'(r_i);
        key_wa = r_v[NVA-1:0]; key_ra = r_va[NVA-1:0];
        unique case (r_state)
            S_CLR: begin
                pos_we = 1'b1; pos_wa = r_clr[NVA-1:0]; pos_wd = '1;
                if (32'(r_clr) == NUM_VERTICES - 1) n_state = S_IDLE;
            end
            S_IDLE: if (s_in.valid && s_in.ready) n_state = S_DEC;
            S_DEC: n_state = S_DEC2;
            S_DEC2: begin
                n_state = S_DONE;
                if (r_mode == imh_pkg::MODE_POP) begin
                    if (r_cnt != '0) n_state = S_POP1;
                end else if (v_ok && r_mode == imh_pkg::MODE_PUSH) begin
                    if (!r_pos_rd[PW-1]) n_state = S_DONE;
                    else if (32'(r_cnt) + 1 < HEAP_SLOTS) begin
                        key_we = 1'b1; slot_we = 1'b1;
                        slot_wa = r_cnt[SA-1:0]; slot_wd = r_v;
                        pos_we = 1'b1; pos_wa = r_v[NVA-1:0]; pos_wd = PW'(r_cnt);
                        n_state = S_UPRD;
                    end
                end else if (v_ok && r_mode == imh_pkg::MODE_UPDATE) begin
                    if (!r_pos_rd[PW-1]) begin
                        key_we = 1'b1; n_state = S_UPRD;
                    end
                end
            end
            S_POP1: begin
                slot_ra = SA'(r_cnt - 1'b1);
                n_state = S_POP2;
            end
            S_POP2: begin
                // root in r_va, last in r_slot_rd
                slot_we = 1'b1; slot_wa = '0; slot_wd = r_slot_rd;
                pos_we = 1'b1; pos_wa = r_slot_rd[NVA-1:0]; pos_wd = '0;
                n_state = (r_phase == 2'd1) ? S_DNRD : S_POP2;
                if (r_phase == 2'd1) begin
                    pos_we = 1'b1; pos_wa = r_popped[NVA-1:0]; pos_wd = '1;
                    slot_we = 1'b0;
                end
            end
            S_UPRD: begin
                if (r_i == '0) n_state = S_DONE;
                else begin
                    slot_ra = parent[SA-1:0];
                    n_state = S_UPK1;
                end
            end
            S_UPK1: begin
                key_ra = r_slot_rd[NVA-1:0];
                n_state = S_UPK2;
            end
            S_UPK2: begin
                key_ra = r_va[NVA-1:0];
                n_state = S_UPCMP;
            end
            S_UPCMP: n_state = (r_key_rd < r_kb) ? S_SWP1 : S_DONE;
            S_DNRD: begin
                if (child >= IW'(r_cnt)) n_state = S_DONE;
                else begin
                    slot_ra = child[SA-1:0];
                    n_state = S_DNK1;
                end
            end
            S_DNK1: begin
                slot_ra = SA'(child + 1'b1);
                key_ra = r_slot_rd[NVA-1:0];
                n_state = S_DNK2;
            end
            S_DNK2: begin
                key_ra = r_slot_rd[NVA-1:0];
                n_state = S_DNK3;
            end
            S_DNK3: begin
                key_ra = r_va[NVA-1:0];
                n_state = S_DNCMP;
            end
            S_DNCMP: n_state = (r_key_rd < r_kc) ? S_DONE : S_SWP1;
            S_SWP1: begin
                // slot i gets other vertex vb at i; slot c gets va
                slot_we = 1'b1; slot_wa = r_i[SA-1:0]; slot_wd = r_vb;
                pos_we = 1'b1; pos_wa = r_vb[NVA-1:0]; pos_wd = PW'(r_i);
                n_state = S_SWP2;
            end
            S_SWP2: begin
                slot_we = 1'b1; slot_wa = r_c[SA-1:0]; slot_wd = r_va;
                pos_we = 1'b1; pos_wa = r_va[NVA-1:0]; pos_wd = PW'(r_c);
                n_state = (r_mode == imh_pkg::MODE_POP) ? S_DNRD : S_UPRD;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_phase  <= '0;
        end else begin
            r_state <= n_state;
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (s_in.valid && s_in.ready) begin
                    r_mode <= s_in.mode;
                    r_v    <= s_in.vertex;
                    r_key  <= KEY_BITS'(s_in.key);
                    r_i    <= '0;
                    r_phase <= '0;
                end
                S_DEC: ;
                S_DEC2: begin
                    r_popped <= '0;
                    if (r_mode == imh_pkg::MODE_POP) begin
                        r_status <= (r_cnt == '0) ? imh_pkg::ST_EMPTY : imh_pkg::ST_OK;
                        r_va <= r_slot_rd;
                    end else if (v_ok && r_mode == imh_pkg::MODE_PUSH) begin
                        if (!r_pos_rd[PW-1]) r_status <= imh_pkg::ST_DUP;
                        else if (32'(r_cnt) + 1 < HEAP_SLOTS) begin
                            r_status <= imh_pkg::ST_OK;
                            r_i <= IW'(r_cnt); r_va <= r_v;
                            r_cnt <= r_cnt + 1'b1;
                        end else r_status <= imh_pkg::ST_FULL;
                    end else if (v_ok && r_mode == imh_pkg::MODE_UPDATE) begin
                        r_status <= imh_pkg::ST_OK;
                        r_i <= IW'(r_pos_rd[PW-2:0]); r_va <= r_v;
                    end else r_status <= imh_pkg::ST_OK;
                end
                S_POP2: begin
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == 2'd0) begin
                        r_popped <= r_va;
                        r_cnt <= r_cnt - 1'b1;
                        r_va <= r_slot_rd;
                    end else r_i <= '0;
                end
                S_UPRD: r_c <= parent;
                S_UPK1: r_vb <= r_slot_rd;
                S_UPK2: r_kb <= r_key_rd;
                S_UPCMP: ;
                S_DNRD: r_c <= child;
                S_DNK1: r_vb <= r_slot_rd;
                S_DNK2: begin r_kb <= r_key_rd; r_vc <= r_slot_rd; end
                S_DNK3: begin
                    if (child + 1'b1 < IW'(r_cnt) && r_key_rd < r_kb) begin
                        r_kc <= r_key_rd; r_vb <= r_vc; r_c <= child + 1'b1;
                    end else r_kc <= r_kb;
                end
                S_DNCMP: ;
                S_SWP1: ;
                S_SWP2: r_i <= r_c;
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_pos <= (r_mode != imh_pkg::MODE_POP && v_ok) ? r_pos_rd : '1;
                end
                default: ;
            endcase
        end
    end
endmodule
